// ===== sv/htsp_pkg.sv =====
// shared types and constants of the huffman table stream parser
package htsp_pkg;

  // marker byte and record geometry
  localparam logic [7:0] MARK_BYTE    = 8'h23;
  localparam int         RECORD_BYTES = 6;
  localparam int         POS_W        = 3;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(RECORD_BYTES - 1);
  localparam logic [39:0] MARK_PREFIX = {5{MARK_BYTE}};
  localparam logic [7:0] FULL_BITS    = 8'd8;

  // result kinds
  typedef enum logic [1:0] {
    KIND_ENTRY   = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  // error codes
  typedef enum logic [1:0] {
    ERR_TRUNCATED  = 2'd0,
    ERR_NO_PAYLOAD = 2'd1,
    ERR_NO_COUNT   = 2'd2
  } err_t;

  // parser phase, one-hot
  typedef enum logic [1:0] {
    PH_TABLE   = 2'b01,
    PH_PAYLOAD = 2'b10
  } phase_t;

  // one input word
  typedef struct packed {
    logic [7:0] byte_value;
    logic       is_final;
  } item_t;

  // one result word
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  symbol;
    logic [31:0] code_word;
    logic [7:0]  code_length;
    logic [7:0]  payload_byte;
    logic [7:0]  valid_bits;
    logic [1:0]  error_code;
    logic        stream_end;
  } result_t;

endpackage

// ===== sv/htsp_input_reg.sv =====
// input register stage with flow control toward the parse core
module htsp_input_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       byte_value,
  input  logic             is_final,
  input  logic             advance_ok,
  output logic             step,
  output htsp_pkg::item_t  item
);

  logic full;

  // the held word moves on when the output side can take its result
  assign step     = full && advance_ok;
  assign in_ready = !full || advance_ok;

  // occupancy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_ready) begin
      full <= in_valid;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.byte_value <= byte_value;
      item.is_final   <= is_final;
    end
  end

endmodule

// ===== sv/htsp_parse_core.sv =====
// parser state and the per-word decode of table records and payload
module htsp_parse_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  htsp_pkg::item_t    item,
  output logic               has_result,
  output htsp_pkg::result_t  result
);

  htsp_pkg::phase_t             phase, phase_next;
  logic [htsp_pkg::POS_W-1:0]   record_position, record_position_next;
  logic [39:0]                  record_buffer, record_buffer_next;
  logic [7:0]                   held_byte, held_byte_next;
  logic                         held_valid, held_valid_next;

  // next state and result for the held word
  always_comb begin
    phase_next           = phase;
    record_position_next = record_position;
    record_buffer_next   = record_buffer;
    held_byte_next       = held_byte;
    held_valid_next      = held_valid;
    has_result           = 1'b0;
    result               = '0;
    if (phase == htsp_pkg::PH_TABLE) begin
      if (record_position != htsp_pkg::LAST_POS) begin
        // collect record bytes, first byte ends up highest
        record_buffer_next   = {record_buffer[31:0], item.byte_value};
        record_position_next = record_position + htsp_pkg::POS_W'(1);
        if (item.is_final) begin
          has_result           = 1'b1;
          result.kind          = htsp_pkg::KIND_ERROR;
          result.error_code    = htsp_pkg::ERR_TRUNCATED;
          result.stream_end    = 1'b1;
          record_position_next = '0;
          held_valid_next      = 1'b0;
        end
      end else begin
        record_position_next = '0;
        if (record_buffer == htsp_pkg::MARK_PREFIX &&
            item.byte_value == htsp_pkg::MARK_BYTE) begin
          // end-of-table marker
          if (item.is_final) begin
            has_result        = 1'b1;
            result.kind       = htsp_pkg::KIND_ERROR;
            result.error_code = htsp_pkg::ERR_NO_PAYLOAD;
            result.stream_end = 1'b1;
          end else begin
            phase_next      = htsp_pkg::PH_PAYLOAD;
            held_valid_next = 1'b0;
          end
        end else if (item.is_final) begin
          has_result        = 1'b1;
          result.kind       = htsp_pkg::KIND_ERROR;
          result.error_code = htsp_pkg::ERR_TRUNCATED;
          result.stream_end = 1'b1;
        end else begin
          // complete table entry
          has_result         = 1'b1;
          result.kind        = htsp_pkg::KIND_ENTRY;
          result.symbol      = record_buffer[39:32];
          result.code_word   = record_buffer[31:0];
          result.code_length = item.byte_value;
        end
      end
    end else begin
      if (item.is_final) begin
        has_result      = 1'b1;
        result.stream_end = 1'b1;
        phase_next      = htsp_pkg::PH_TABLE;
        held_valid_next = 1'b0;
        if (!held_valid) begin
          result.kind       = htsp_pkg::KIND_ERROR;
          result.error_code = htsp_pkg::ERR_NO_COUNT;
        end else begin
          // last data byte takes its bit count from the final byte
          result.kind         = htsp_pkg::KIND_PAYLOAD;
          result.payload_byte = held_byte;
          result.valid_bits   = item.byte_value;
        end
      end else if (held_valid) begin
        has_result          = 1'b1;
        result.kind         = htsp_pkg::KIND_PAYLOAD;
        result.payload_byte = held_byte;
        result.valid_bits   = htsp_pkg::FULL_BITS;
        held_byte_next      = item.byte_value;
      end else begin
        held_byte_next  = item.byte_value;
        held_valid_next = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= htsp_pkg::PH_TABLE;
      record_position <= '0;
      held_valid      <= 1'b0;
    end else if (step) begin
      phase           <= phase_next;
      record_position <= record_position_next;
      held_valid      <= held_valid_next;
    end
  end

  // data state, only read once filled
  always_ff @(posedge clk) begin
    if (step) begin
      record_buffer <= record_buffer_next;
      held_byte     <= held_byte_next;
    end
  end

endmodule

// ===== sv/htsp_output_reg.sv =====
// result register driving the output channel
module htsp_output_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  htsp_pkg::result_t  result,
  output logic               advance_ok,
  output logic               out_valid,
  input  logic               out_ready,
  output htsp_pkg::result_t  held
);

  // free when empty or being drained this cycle
  assign advance_ok = !out_valid || out_ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance_ok) begin
      out_valid <= load;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load && advance_ok) begin
      held <= result;
    end
  end

endmodule

// ===== sv/huffman_table_stream_parser.sv =====
// top level of the huffman table stream parser
// an accepted input word passes from the input register through the parse core into the result register
// throughput: one input word per cycle while the output side keeps up
// the input register and the result register each hold one word
// reset: synchronous rst returns to the table phase with empty registers
module huffman_table_stream_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  byte_value,
  input  logic        is_final,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [7:0]  symbol,
  output logic [31:0] code_word,
  output logic [7:0]  code_length,
  output logic [7:0]  payload_byte,
  output logic [7:0]  valid_bits,
  output logic [1:0]  error_code,
  output logic        stream_end
);

  htsp_pkg::item_t   item;
  htsp_pkg::result_t result;
  htsp_pkg::result_t held;
  logic              step;
  logic              advance_ok;
  logic              has_result;

  // input word register
  htsp_input_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .byte_value (byte_value),
    .is_final   (is_final),
    .advance_ok (advance_ok),
    .step       (step),
    .item       (item)
  );

  // record and payload decode
  htsp_parse_core u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .item       (item),
    .has_result (has_result),
    .result     (result)
  );

  // result word register
  htsp_output_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (step && has_result),
    .result     (result),
    .advance_ok (advance_ok),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .held       (held)
  );

  // result fields
  assign kind         = held.kind;
  assign symbol       = held.symbol;
  assign code_word    = held.code_word;
  assign code_length  = held.code_length;
  assign payload_byte = held.payload_byte;
  assign valid_bits   = held.valid_bits;
  assign error_code   = held.error_code;
  assign stream_end   = held.stream_end;

endmodule

// ===== sim/tb.sv =====
// testbench for the huffman table stream parser: queued driver, checking monitor
module tb;

  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AT_WORD = 300;
  localparam int RANDOM_WORDS = 700;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  byte_value = 8'h00;
  logic        is_final = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  symbol;
  logic [31:0] code_word;
  logic [7:0]  code_length;
  logic [7:0]  payload_byte;
  logic [7:0]  valid_bits;
  logic [1:0]  error_code;
  logic        stream_end;

  huffman_table_stream_parser dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .byte_value(byte_value), .is_final(is_final),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .symbol(symbol), .code_word(code_word), .code_length(code_length),
    .payload_byte(payload_byte), .valid_bits(valid_bits),
    .error_code(error_code), .stream_end(stream_end)
  );

  // words still to send and results still owed
  htsp_pkg::item_t   pending_bytes[$];
  htsp_pkg::result_t expected_words[$];

  // shadow parser state
  htsp_pkg::phase_t ph = htsp_pkg::PH_TABLE;
  logic [2:0]  rec_pos = '0;
  logic [39:0] rec_buf = '0;
  logic [7:0]  held_b = '0;
  logic        held_v = 1'b0;

  int mismatches = 0;
  int words_in = 0;
  int words_out = 0;
  int n_files = 0;
  int n_entries = 0;
  int n_payload = 0;
  int n_errors = 0;
  int in_stalls = 0;
  int cycles = 0;
  int in_wait = 0;
  int out_wait = 0;
  logic hold_off = 1'b0;
  logic hold_done = 1'b0;
  int hold_cnt = 0;

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  task automatic note_mismatch(string what);
    mismatches++;
    $display("mismatch at result %0d: %s", words_out, what);
  endtask

  task automatic clear_parser();
    ph = htsp_pkg::PH_TABLE;
    rec_pos = '0;
    rec_buf = '0;
    held_b = '0;
    held_v = 1'b0;
  endtask

  function automatic htsp_pkg::result_t error_word(htsp_pkg::err_t code);
    htsp_pkg::result_t r;
    r = '0;
    r.kind = htsp_pkg::KIND_ERROR;
    r.error_code = code;
    r.stream_end = 1'b1;
    return r;
  endfunction

  // advance the shadow parser by one byte and queue any result it owes
  task automatic parse_byte(input logic [7:0] b, input logic fin);
    htsp_pkg::result_t r;
    logic [39:0]       rec;
    bit                emit;
    r = '0;
    emit = 1'b0;
    if (ph == htsp_pkg::PH_TABLE) begin
      if (rec_pos < htsp_pkg::LAST_POS) begin
        rec_buf = {rec_buf[31:0], b};
        rec_pos = rec_pos + 3'd1;
        if (fin) begin
          r = error_word(htsp_pkg::ERR_TRUNCATED);
          emit = 1'b1;
          clear_parser();
        end
      end else begin
        rec = rec_buf;
        rec_pos = '0;
        rec_buf = '0;
        if (rec == htsp_pkg::MARK_PREFIX && b == htsp_pkg::MARK_BYTE) begin
          // marker record ends the table
          if (fin) begin
            r = error_word(htsp_pkg::ERR_NO_PAYLOAD);
            emit = 1'b1;
            clear_parser();
          end else begin
            ph = htsp_pkg::PH_PAYLOAD;
            held_v = 1'b0;
            held_b = '0;
          end
        end else if (fin) begin
          // a completed ordinary record is dropped when the file ends on it
          r = error_word(htsp_pkg::ERR_TRUNCATED);
          emit = 1'b1;
          clear_parser();
        end else begin
          r.kind = htsp_pkg::KIND_ENTRY;
          r.symbol = rec[39:32];
          r.code_word = rec[31:0];
          r.code_length = b;
          emit = 1'b1;
        end
      end
    end else begin
      // payload phase: one byte is held back until its successor arrives
      if (fin) begin
        if (!held_v) begin
          r = error_word(htsp_pkg::ERR_NO_COUNT);
        end else begin
          r.kind = htsp_pkg::KIND_PAYLOAD;
          r.payload_byte = held_b;
          r.valid_bits = b;
          r.stream_end = 1'b1;
        end
        emit = 1'b1;
        clear_parser();
      end else if (held_v) begin
        r.kind = htsp_pkg::KIND_PAYLOAD;
        r.payload_byte = held_b;
        r.valid_bits = htsp_pkg::FULL_BITS;
        emit = 1'b1;
        held_b = b;
      end else begin
        held_b = b;
        held_v = 1'b1;
      end
    end
    if (emit) begin
      expected_words.push_back(r);
      case (r.kind)
        htsp_pkg::KIND_ENTRY:   n_entries++;
        htsp_pkg::KIND_PAYLOAD: n_payload++;
        default:                n_errors++;
      endcase
    end
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) note_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // compare one accepted result word with the oldest expectation
  task automatic check_word();
    htsp_pkg::result_t got, want;
    got = {kind, symbol, code_word, code_length, payload_byte, valid_bits, error_code,
           stream_end};
    if (expected_words.size() == 0) begin
      note_mismatch("result word with none expected");
    end else begin
      want = expected_words.pop_front();
      check_field("kind", 32'(got.kind), 32'(want.kind));
      check_field("symbol", 32'(got.symbol), 32'(want.symbol));
      check_field("code_word", got.code_word, want.code_word);
      check_field("code_length", 32'(got.code_length), 32'(want.code_length));
      check_field("payload_byte", 32'(got.payload_byte), 32'(want.payload_byte));
      check_field("valid_bits", 32'(got.valid_bits), 32'(want.valid_bits));
      check_field("error_code", 32'(got.error_code), 32'(want.error_code));
      check_field("stream_end", 32'(got.stream_end), 32'(want.stream_end));
    end
  endtask

  // gap drawn per word, zero during burst stretches
  function automatic int draw_gap(bit burst);
    if (burst) return 0;
    return $urandom_range(0, 16);
  endfunction

  // stimulus building
  task automatic push_byte(logic [7:0] b, logic fin);
    htsp_pkg::item_t it;
    it.byte_value = b;
    it.is_final = fin;
    pending_bytes.push_back(it);
  endtask

  task automatic push_record(logic [7:0] sym, logic [31:0] code, logic [7:0] len, logic fin);
    push_byte(sym, 1'b0);
    push_byte(code[31:24], 1'b0);
    push_byte(code[23:16], 1'b0);
    push_byte(code[15:8], 1'b0);
    push_byte(code[7:0], 1'b0);
    push_byte(len, fin);
  endtask

  task automatic push_marker(logic fin);
    push_record(htsp_pkg::MARK_BYTE, {4{htsp_pkg::MARK_BYTE}}, htsp_pkg::MARK_BYTE, fin);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return htsp_pkg::MARK_BYTE;
      default: return 8'($urandom);
    endcase
  endfunction

  // record bytes, sometimes mostly marker bytes to land near the marker
  task automatic push_random_record(int nbytes, logic fin);
    bit hashy;
    hashy = ($urandom_range(0, 5) == 0);
    for (int i = 0; i < nbytes; i++) begin
      push_byte((hashy && $urandom_range(0, 4) != 0) ? htsp_pkg::MARK_BYTE : pick_byte(),
                fin && (i == nbytes - 1));
    end
  endtask

  task automatic push_random_file();
    int sel, nrec, nload;
    sel = $urandom_range(0, 99);
    nrec = $urandom_range(0, 4);
    n_files++;
    if (sel < 94) begin
      for (int i = 0; i < nrec; i++) push_random_record(6, 1'b0);
    end
    if (sel < 70) begin
      // well-formed file
      push_marker(1'b0);
      nload = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 12);
      for (int i = 0; i < nload; i++) push_byte(pick_byte(), 1'b0);
      push_byte(($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 8)) : 8'($urandom),
                1'b1);
    end else if (sel < 80) begin
      push_random_record($urandom_range(1, 6), 1'b1);
    end else if (sel < 87) begin
      push_marker(1'b1);
    end else if (sel < 94) begin
      push_marker(1'b0);
      push_byte(pick_byte(), 1'b1);
    end else begin
      // noise with scattered final flags
      for (int i = $urandom_range(1, 10); i > 0; i--) begin
        push_byte(8'($urandom), $urandom_range(0, 3) == 0);
      end
    end
  endtask

  // driver: one word at a time from the pending queue
  always @(posedge clk) begin : driver
    int              w;
    htsp_pkg::item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      in_wait <= 0;
    end else begin
      w = in_wait;
      if (in_valid && !in_ready) in_stalls <= in_stalls + 1;
      if (in_valid && in_ready) begin
        parse_byte(byte_value, is_final);
        words_in <= words_in + 1;
      end
      if (!in_valid || in_ready) begin
        if (w == 0 && pending_bytes.size() > 0) begin
          nxt = pending_bytes.pop_front();
          in_valid <= 1'b1;
          byte_value <= nxt.byte_value;
          is_final <= nxt.is_final;
          w = draw_gap((words_in / 64) % 4 == 1 || hold_off);
        end else begin
          in_valid <= 1'b0;
          if (w > 0) w = w - 1;
        end
      end
      in_wait <= w;
    end
  end

  // monitor: accepts result words with random stalls
  always @(posedge clk) begin : monitor
    int s;
    if (rst) begin
      out_ready <= 1'b0;
      out_wait <= 0;
    end else begin
      s = out_wait;
      if (out_valid && out_ready) begin
        check_word();
        words_out <= words_out + 1;
        s = draw_gap((words_out / 48) % 4 == 2);
      end else if (s > 0) begin
        s = s - 1;
      end
      out_wait <= s;
      out_ready <= (s == 0) && !hold_off;
    end
  end

  // one long receiver hold-off so the block fills and stalls its input
  always @(posedge clk) begin
    if (rst) begin
      hold_off <= 1'b0;
      hold_done <= 1'b0;
      hold_cnt <= 0;
    end else if (!hold_done && !hold_off && words_in >= HOLD_AT_WORD) begin
      hold_off <= 1'b1;
      hold_cnt <= 0;
    end else if (hold_off) begin
      if (hold_cnt == HOLD_CYCLES - 1) begin
        hold_off <= 1'b0;
        hold_done <= 1'b1;
      end else begin
        hold_cnt <= hold_cnt + 1;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_words.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int total;
    // well-formed file with extreme record fields and extreme bit counts
    push_record(8'hFF, 32'hFFFF_FFFF, 8'hFF, 1'b0);
    push_marker(1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b1);
    // file ends inside the table
    push_byte(8'h00, 1'b0);
    push_byte(8'h5A, 1'b1);
    // nothing after the marker
    push_marker(1'b1);
    // a single byte after the marker
    push_marker(1'b0);
    push_byte(8'h00, 1'b1);
    n_files = 4;
    total = pending_bytes.size() + RANDOM_WORDS;
    while (pending_bytes.size() < total) push_random_file();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pending_bytes.size() > 0 || in_valid || expected_words.size() > 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d files, %0d bytes in, %0d results out in %0d cycles", n_files, words_in,
             words_out, cycles);
    $display("%0d table entries, %0d payload bytes, %0d errors, %0d input stall cycles",
             n_entries, n_payload, n_errors, in_stalls);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
